@@ sv/utf8sd_pkg.sv @@
// utf8sd_pkg: shared types and constants for the utf-8 stream decoder
// used by utf8sd_decode, utf8sd_emit and utf8_stream_decoder
package utf8sd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CpW-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CpW-1:0] MIN_TWO  = 21'h000080;
  localparam logic [CpW-1:0] MIN_THREE = 21'h000800;
  localparam logic [CpW-1:0] MIN_FOUR = 21'h010000;

  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // results of one word: rep_cnt replacements, then an optional tail result
  typedef struct packed {
    logic [1:0]     rep_cnt;
    logic           tail_v;
    logic [CpW-1:0] tail_cp;
    logic           tail_rep;
  } run_t;

  typedef struct packed {
    logic [1:0] need;
    logic [1:0] have;
  } seq_status_t;

endpackage

@@ sv/utf8sd_decode.sv @@
// utf8sd_decode: sequence state registers and per-word decode logic
// depends on utf8sd_pkg
module utf8sd_decode (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     end_of_input_i,
  output utf8sd_pkg::run_t         run_o,
  output logic                     has_results_o,
  output utf8sd_pkg::seq_status_t  status_o
);
  import utf8sd_pkg::*;

  logic [1:0]     need_q, need_d;
  logic [1:0]     have_q, have_d;
  logic [CpW-1:0] part_q, part_d;

  logic           lead_tail_v;
  logic [CpW-1:0] lead_cp;
  logic           lead_rep;
  logic           lead_open;
  logic [1:0]     lead_need;
  logic [CpW-1:0] lead_bits;
  logic           cont;
  logic [CpW-1:0] cont_cp;
  logic [1:0]     have_inc;
  logic           bad;
  run_t           run;

  // a word taken as a new lead
  always_comb begin
    lead_tail_v = 1'b1;
    lead_cp     = REPL_CP;
    lead_rep    = 1'b1;
    lead_open   = 1'b0;
    lead_need   = NEED_NONE;
    lead_bits   = '0;
    if (!data_byte_i[7]) begin
      lead_cp  = {13'd0, data_byte_i};
      lead_rep = 1'b0;
    end else if (data_byte_i[7:5] == 3'b110) begin
      lead_open = 1'b1;
      lead_need = NEED_ONE;
      lead_bits = {16'd0, data_byte_i[4:0]};
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_open = 1'b1;
      lead_need = NEED_TWO;
      lead_bits = {17'd0, data_byte_i[3:0]};
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_open = 1'b1;
      lead_need = NEED_THREE;
      lead_bits = {18'd0, data_byte_i[2:0]};
    end
    // lead on the final word gives one replacement
    if (lead_open && end_of_input_i) begin
      lead_open = 1'b0;
    end
    if (lead_open) begin
      lead_tail_v = 1'b0;
    end
  end

  assign cont     = (data_byte_i[7:6] == 2'b10);
  assign cont_cp  = {part_q[14:0], data_byte_i[5:0]};
  assign have_inc = have_q + 2'd1;

  assign bad = ((need_q == NEED_ONE)   && (cont_cp < MIN_TWO))   ||
               ((need_q == NEED_TWO)   && (cont_cp < MIN_THREE)) ||
               ((need_q == NEED_THREE) && (cont_cp < MIN_FOUR))  ||
               (cont_cp > MAX_CP) ||
               ((cont_cp >= SURR_LO) && (cont_cp <= SURR_HI));

  always_comb begin
    run.rep_cnt  = 2'd0;
    run.tail_v   = lead_tail_v;
    run.tail_cp  = lead_cp;
    run.tail_rep = lead_rep;
    need_d       = lead_open ? lead_need : NEED_NONE;
    have_d       = 2'd0;
    part_d       = lead_open ? lead_bits : '0;
    if (need_q != NEED_NONE) begin
      if (cont) begin
        run.tail_v   = 1'b1;
        run.tail_cp  = REPL_CP;
        run.tail_rep = 1'b1;
        need_d       = NEED_NONE;
        part_d       = '0;
        if (have_inc >= need_q) begin
          run.tail_cp  = bad ? REPL_CP : cont_cp;
          run.tail_rep = bad;
        end else if (end_of_input_i) begin
          run.rep_cnt = have_inc;
        end else begin
          run.tail_v = 1'b0;
          need_d     = need_q;
          have_d     = have_inc;
          part_d     = cont_cp;
        end
      end else begin
        // broken sequence: lead and taken continuations, then reprocess
        run.rep_cnt = have_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= NEED_NONE;
      have_q <= 2'd0;
      part_q <= '0;
    end else if (accept_i) begin
      need_q <= need_d;
      have_q <= have_d;
      part_q <= part_d;
    end
  end

  assign run_o         = run;
  assign has_results_o = (run.rep_cnt != 2'd0) || run.tail_v;
  assign status_o      = '{need: need_q, have: have_q};

endmodule

@@ sv/utf8sd_emit.sv @@
// utf8sd_emit: holds the results of one word and drains them into the output register
// depends on utf8sd_pkg
module utf8sd_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  utf8sd_pkg::run_t              run_i,
  input  logic                          run_load_i,
  output logic                          run_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8sd_pkg::CpW-1:0]    scalar_value_o,
  output logic                          is_replacement_o,
  output logic                          last_of_run_o
);
  import utf8sd_pkg::*;

  logic           run_v_q;
  run_t           run_q;
  logic           out_v_q;
  logic [CpW-1:0] cp_q;
  logic           rep_q;
  logic           last_q;

  logic           load_out;
  logic           take;
  logic [CpW-1:0] cur_cp;
  logic           cur_rep;
  logic           cur_last;

  assign load_out = !out_v_q || !out_stall_i;
  assign take     = run_v_q && load_out;

  always_comb begin
    if (run_q.rep_cnt != 2'd0) begin
      cur_cp   = REPL_CP;
      cur_rep  = 1'b1;
      cur_last = (run_q.rep_cnt == 2'd1) && !run_q.tail_v;
    end else begin
      cur_cp   = run_q.tail_cp;
      cur_rep  = run_q.tail_rep;
      cur_last = 1'b1;
    end
  end

  assign run_ready_o = !run_v_q || (take && cur_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (run_load_i) begin
        run_v_q <= 1'b1;
      end else if (take && cur_last) begin
        run_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= run_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_load_i) begin
      run_q <= run_i;
    end else if (take && !cur_last) begin
      run_q.rep_cnt <= run_q.rep_cnt - 2'd1;
    end
    if (take) begin
      cp_q   <= cur_cp;
      rep_q  <= cur_rep;
      last_q <= cur_last;
    end
  end

  assign out_valid_o      = out_v_q;
  assign scalar_value_o   = cp_q;
  assign is_replacement_o = rep_q;
  assign last_of_run_o    = last_q;

endmodule

@@ sv/utf8_stream_decoder.sv @@
// utf8_stream_decoder: streaming utf-8 decoder, one word in, up to four code points out
// the results of a word pass through the run register and then the output register
// throughput: 1 word per cycle while each word gives at most one result and the output
//   is not stalled; a word that gives more results stalls the input until its last is taken
// reset: asynchronous active low, clears the open sequence and empties the output
// depends on utf8sd_pkg, utf8sd_decode, utf8sd_emit
module utf8_stream_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_input_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [utf8sd_pkg::CpW-1:0]  scalar_value_o,
  output logic                        is_replacement_o,
  output logic                        last_of_run_o
);
  import utf8sd_pkg::*;

  logic        accept;
  logic        run_ready;
  logic        has_results;
  run_t        run;
  seq_status_t status;

  assign in_stall_o = !run_ready;
  assign accept     = in_valid_i && run_ready;

  utf8sd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .run_o          (run),
    .has_results_o  (has_results),
    .status_o       (status)
  );

  utf8sd_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .run_i            (run),
    .run_load_i       (accept && has_results),
    .run_ready_o      (run_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scalar_value_o   (scalar_value_o),
    .is_replacement_o (is_replacement_o),
    .last_of_run_o    (last_of_run_o)
  );

  a_have_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.need != NEED_NONE) |-> (status.have < status.need))
    else $error("continuation count reached sequence length");

  a_closed_no_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.need == NEED_NONE) |-> (status.have == 2'd0))
    else $error("continuation count set with no open sequence");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_input_i) |=> (status.need == NEED_NONE))
    else $error("sequence still open after final word");

  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_replacement_o) |-> (scalar_value_o == REPL_CP))
    else $error("replacement result with wrong code point");

  a_scalar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_replacement_o) |->
      ((scalar_value_o <= MAX_CP) &&
       ((scalar_value_o < SURR_LO) || (scalar_value_o > SURR_HI))))
    else $error("decoded value is not a scalar value");

endmodule

@@ bench/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// utf8_stream_decoder_tb: self-checking bench for the utf-8 stream decoder
// a directed table of byte streams, then random streams, checked against a behavioral decoder
// depends on utf8sd_pkg and utf8_stream_decoder
module utf8_stream_decoder_tb;
  import utf8sd_pkg::*;

  localparam int unsigned RandWords  = 300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned LongHold   = 300;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           rep;
    logic           last;
  } cp_result_t;

  // one word of stimulus; fixed rows carry their single result typed in
  typedef struct packed {
    logic [7:0]     b;
    logic           eoi;
    logic           fixed;
    logic [CpW-1:0] fixed_cp;
    logic           fixed_rep;
  } byte_word_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  logic [7:0]     data_byte_i;
  logic           end_of_input_i;
  logic           out_valid_o;
  logic           out_stall_i;
  logic [CpW-1:0] scalar_value_o;
  logic           is_replacement_o;
  logic           last_of_run_o;

  utf8_stream_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_input_i   (end_of_input_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scalar_value_o   (scalar_value_o),
    .is_replacement_o (is_replacement_o),
    .last_of_run_o    (last_of_run_o)
  );

  byte_word_t     byte_stream_q[$];
  cp_result_t     cp_expected_q[$];
  cp_result_t     run_q[$];
  cp_result_t     cp_oldest;
  logic [1:0]     seq_need;
  logic [1:0]     seq_have;
  logic [CpW-1:0] seq_bits;
  int unsigned    fail_cnt  = 0;
  int unsigned    cp_seen   = 0;
  int unsigned    cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("utf8_stream_decoder: mismatch");
      $finish;
    end
  end

  function automatic void put_cp(logic [CpW-1:0] cp, logic rep);
    cp_result_t r;
    r.cp   = cp;
    r.rep  = rep;
    r.last = 1'b0;
    run_q = {run_q, r};
  endfunction

  function automatic void clear_seq();
    seq_need = NEED_NONE;
    seq_have = 2'd0;
    seq_bits = '0;
  endfunction

  function automatic void open_lead(logic [7:0] b, logic eoi);
    logic [1:0]     extra;
    logic [CpW-1:0] bits;
    extra = NEED_NONE;
    bits  = '0;
    if (!b[7]) begin
      put_cp({13'd0, b}, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      extra = NEED_ONE;
      bits  = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      extra = NEED_TWO;
      bits  = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      extra = NEED_THREE;
      bits  = {18'd0, b[2:0]};
    end else begin
      put_cp(REPL_CP, 1'b1);
    end
    if (extra != NEED_NONE) begin
      if (eoi) begin
        put_cp(REPL_CP, 1'b1);
      end else begin
        seq_need = extra;
        seq_have = 2'd0;
        seq_bits = bits;
      end
    end
  endfunction

  // results of one accepted word go to run_q, last one flagged
  function automatic void decode_word(logic [7:0] b, logic eoi);
    logic [2:0]     have;
    logic [CpW-1:0] cp;
    logic           bad;
    run_q.delete();
    if (seq_need == NEED_NONE) begin
      open_lead(b, eoi);
    end else if (b[7:6] == 2'b10) begin
      have = {1'b0, seq_have} + 3'd1;
      cp   = {seq_bits[CpW-7:0], b[5:0]};
      if (have >= {1'b0, seq_need}) begin
        bad = (seq_need == NEED_ONE && cp < MIN_TWO) ||
              (seq_need == NEED_TWO && cp < MIN_THREE) ||
              (seq_need == NEED_THREE && cp < MIN_FOUR) ||
              cp > MAX_CP || (cp >= SURR_LO && cp <= SURR_HI);
        put_cp(bad ? REPL_CP : cp, bad);
        clear_seq();
      end else if (eoi) begin
        repeat (int'(have) + 1) put_cp(REPL_CP, 1'b1);
        clear_seq();
      end else begin
        seq_have = have[1:0];
        seq_bits = cp;
      end
    end else begin
      repeat (int'(seq_have) + 1) put_cp(REPL_CP, 1'b1);
      clear_seq();
      open_lead(b, eoi);
    end
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_row(logic [7:0] b, logic eoi, logic fixed = 1'b0,
                                  logic [CpW-1:0] cp = '0, logic rep = 1'b0);
    byte_word_t w;
    w.b         = b;
    w.eoi       = eoi;
    w.fixed     = fixed;
    w.fixed_cp  = cp;
    w.fixed_rep = rep;
    byte_stream_q = {byte_stream_q, w};
  endfunction

  function automatic logic rand_eoi();
    return $urandom_range(0, 15) == 0;
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_lead(int unsigned len);
    case (len)
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic void build_random();
    int unsigned pick;
    int unsigned len;
    int unsigned taken;
    pick = $urandom_range(0, 15);
    if (pick < 4) begin
      add_row(8'($urandom_range(0, 127)), rand_eoi());
    end else if (pick < 12) begin
      len = $urandom_range(2, 4);
      add_row(rand_lead(len), rand_eoi());
      for (int k = 1; k < len; k++) add_row(rand_cont(), rand_eoi());
    end else if (pick < 14) begin
      len   = $urandom_range(2, 4);
      taken = $urandom_range(0, len - 2);
      add_row(rand_lead(len), 1'b0);
      for (int k = 0; k < taken; k++) add_row(rand_cont(), 1'b0);
      add_row(8'($urandom_range(0, 255)), rand_eoi());
    end else begin
      add_row(8'($urandom_range(0, 255)), rand_eoi());
    end
  endfunction

  // sender
  initial begin
    byte_word_t  w;
    cp_result_t  r;
    int unsigned gap;
    int unsigned n_directed;
    logic        stalled;
    logic        burst;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = 8'h00;
    end_of_input_i = 1'b0;
    burst          = 1'b0;
    clear_seq();

    // ascii extremes and invalid leads
    add_row(8'h00, 1'b0, 1'b1, 21'h000000, 1'b0);
    add_row(8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0);
    add_row(8'h80, 1'b0, 1'b1, REPL_CP, 1'b1);
    add_row(8'hFF, 1'b0, 1'b1, REPL_CP, 1'b1);
    // two-byte form
    add_row(8'hC2, 1'b0);
    add_row(8'hA9, 1'b0);
    // highest scalar value
    add_row(8'hF4, 1'b0);
    add_row(8'h8F, 1'b0);
    add_row(8'hBF, 1'b0);
    add_row(8'hBF, 1'b0, 1'b1, MAX_CP, 1'b0);
    // overlong
    add_row(8'hC0, 1'b0);
    add_row(8'h80, 1'b0, 1'b1, REPL_CP, 1'b1);
    // surrogate
    add_row(8'hED, 1'b0);
    add_row(8'hA0, 1'b0);
    add_row(8'h80, 1'b0, 1'b1, REPL_CP, 1'b1);
    // bad continuation, ascii reprocessed
    add_row(8'hE2, 1'b0);
    add_row(8'h41, 1'b0);
    // bad continuation after one taken, new lead, sequence ends on final word
    add_row(8'hF0, 1'b0);
    add_row(8'h9F, 1'b0);
    add_row(8'hC3, 1'b0);
    add_row(8'hA9, 1'b1);
    // truncated at end of input
    add_row(8'hE2, 1'b0);
    add_row(8'h82, 1'b1);
    // lead on the final word
    add_row(8'hC3, 1'b1, 1'b1, REPL_CP, 1'b1);
    // encoded replacement character is not malformed
    add_row(8'hEF, 1'b0);
    add_row(8'hBF, 1'b0);
    add_row(8'hBD, 1'b0, 1'b1, REPL_CP, 1'b0);
    n_directed = byte_stream_q.size();

    while (byte_stream_q.size() < n_directed + RandWords) build_random();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (byte_stream_q[i]) begin
      w   = byte_stream_q[i];
      gap = burst ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 29) == 0) burst = !burst;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i     <= 1'b1;
      data_byte_i    <= w.b;
      end_of_input_i <= w.eoi;
      do begin
        @(negedge clk_i);
        stalled = in_stall_o;
        @(posedge clk_i);
      end while (stalled);
      decode_word(w.b, w.eoi);
      if (w.fixed) begin
        run_q.delete();
        r.cp   = w.fixed_cp;
        r.rep  = w.fixed_rep;
        r.last = 1'b1;
        run_q = {run_q, r};
      end
      cp_expected_q = {cp_expected_q, run_q};
    end
    in_valid_i <= 1'b0;

    while (cp_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

  // receiver
  initial begin
    int unsigned hold;
    logic        got;
    logic        burst;
    logic        held_long;
    out_stall_i = 1'b0;
    burst       = 1'b0;
    held_long   = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      hold = burst ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 29) == 0) burst = !burst;
      if (!held_long && cp_seen >= 80) begin
        hold      = LongHold;
        held_long = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
    end
  end

  // values at the falling edge hold through the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      cp_seen++;
      if (cp_expected_q.size() == 0) begin
        $display("%0t: word with none expected: expected none, actual cp %h rep %b last %b",
                 $time, scalar_value_o, is_replacement_o, last_of_run_o);
        fail_cnt++;
      end else begin
        cp_oldest = cp_expected_q.pop_front();
        if (scalar_value_o !== cp_oldest.cp) begin
          $display("%0t: scalar_value expected %h actual %h",
                   $time, cp_oldest.cp, scalar_value_o);
          fail_cnt++;
        end
        if (is_replacement_o !== cp_oldest.rep) begin
          $display("%0t: is_replacement expected %b actual %b",
                   $time, cp_oldest.rep, is_replacement_o);
          fail_cnt++;
        end
        if (last_of_run_o !== cp_oldest.last) begin
          $display("%0t: last_of_run expected %b actual %b",
                   $time, cp_oldest.last, last_of_run_o);
          fail_cnt++;
        end
      end
    end
  end

endmodule

@@ sim.f @@
sv/utf8sd_pkg.sv
sv/utf8sd_decode.sv
sv/utf8sd_emit.sv
sv/utf8_stream_decoder.sv
bench/utf8_stream_decoder_tb.sv
